### sv/charlieplex_greyscale_scanner_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the charlieplex greyscale scanner
// Shared concurrent-assertion shorthands, clocked on clk and masked by rst_n.
// ----------------------------------------------------------------------------
`ifndef CHARLIEPLEX_GREYSCALE_SCANNER_TOP_MACROS_SVH
`define CHARLIEPLEX_GREYSCALE_SCANNER_TOP_MACROS_SVH

// Same-cycle implication.
`define CGS_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CGS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/cgs_pkg.sv
// ----------------------------------------------------------------------------
// cgs_pkg
// Shared types and constants for the charlieplex greyscale scanner.
// ----------------------------------------------------------------------------
package cgs_pkg;

    localparam int ROW_COUNT   = 10;
    localparam int LINE_COUNT  = ROW_COUNT + 1;
    localparam int STORE_DEPTH = 2 * LINE_COUNT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int ENTRY_W     = 30;
    localparam int WORD_W      = 28;
    localparam int PAYLOAD_W   = 7;
    localparam int PORT_W      = 16;
    localparam int ROW_W       = 4;
    localparam int PLANE_W     = 2;
    localparam int PLANE_COUNT = 3;
    localparam int REPEAT_W    = 3;
    localparam int BYTE_W      = 8;

    localparam logic [ENTRY_W-1:0] ENTRY_RESET = {ENTRY_W{1'b1}};

    typedef struct packed {
        logic              byte_valid;
        logic [BYTE_W-1:0] rx_byte;
    } tick_item_t;

    typedef struct packed {
        logic [PORT_W-1:0]  line_level;
        logic [PORT_W-1:0]  line_enable;
        logic [ROW_W-1:0]   row_index;
        logic [PLANE_W-1:0] plane_index;
        logic               frame_swapped;
    } result_item_t;

    // Receiver to frame store: write strobe plus buffer selection status.
    typedef struct packed {
        logic               wr_en;
        logic [ADDR_W-1:0]  wr_addr;
        logic [ENTRY_W-1:0] wr_data;
        logic               swap;
        logic               front;
    } store_wr_t;

endpackage

### sv/charlieplex_greyscale_scanner_top.sv
// ----------------------------------------------------------------------------
// charlieplex_greyscale_scanner_top
// Charlieplexed 11-line LED matrix scanner with 3-plane greyscale and serial
// frame loading.
// ----------------------------------------------------------------------------
// Each accepted item is one scan tick: it drives one scan line for one bit
// plane and may carry one received serial byte. The block takes one item per
// clock cycle while tick_stall is low; its result is registered, or parked in
// the skid slot while a result is held. The only path between input and result
// is the frame store read, the line pattern logic and the pin map. A two-entry
// output queue (result register plus one skid slot) lets a tick be taken while
// a result waits, and tick_stall rises only when both slots are full. Rows run
// 0..10; plane d is repeated 2^d full scans before the next plane. Bytes with
// bit 7 set start a 4-byte word of 7-bit payloads; each finished word fills the
// next row of the back buffer, and after 11 words the buffers swap
// (frame_swapped). The pattern for a tick uses the buffer as it stood before
// that tick's byte. After reset both buffers read all ones, so every LED is lit.
// ----------------------------------------------------------------------------
`include "charlieplex_greyscale_scanner_top_macros.svh"

module charlieplex_greyscale_scanner_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  tick_valid,
    output logic                  tick_stall,
    input  cgs_pkg::tick_item_t   tick,
    output logic                  result_valid,
    input  logic                  result_stall,
    output cgs_pkg::result_item_t result
);
    import cgs_pkg::*;

    // Frame store: two buffers of LINE_COUNT words, front half chosen by wr.front.
    logic [ENTRY_W-1:0] store_reg [STORE_DEPTH];

    logic [ROW_W-1:0]    scan_row_reg, scan_row_next;
    logic [PLANE_W-1:0]  scan_plane_reg, scan_plane_next;
    logic [REPEAT_W-1:0] repeat_reg, repeat_next;

    result_item_t out_reg, out_next;
    logic         out_valid_reg, out_valid_next;
    result_item_t skid_reg, skid_next;
    logic         skid_valid_reg, skid_valid_next;

    logic               tick_take;
    logic               result_take;
    store_wr_t          wr;
    logic [ROW_W-1:0]   row_cur;
    logic [PLANE_W-1:0] plane_cur;
    logic [PLANE_W-1:0] plane_adv;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ENTRY_W-1:0] word;
    logic [PORT_W-1:0]  level;
    logic [PORT_W-1:0]  enable;
    result_item_t       item_new;

    assign tick_take    = tick_valid & ~tick_stall;
    assign tick_stall   = skid_valid_reg;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign result_take  = out_valid_reg & ~result_stall;

    cgs_receiver u_receiver (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_take (tick_take & tick.byte_valid),
        .rx_byte   (tick.rx_byte),
        .wr        (wr)
    );

    // Clamp the scan counters and pick this tick's word from the front buffer.
    always_comb
    begin
        row_cur   = (scan_row_reg <= ROW_W'(ROW_COUNT)) ? scan_row_reg : '0;
        plane_cur = (scan_plane_reg < PLANE_W'(PLANE_COUNT)) ? scan_plane_reg : '0;
        rd_addr   = wr.front ? ADDR_W'(LINE_COUNT) + ADDR_W'(row_cur) : ADDR_W'(row_cur);
        word      = store_reg[rd_addr];
    end

    cgs_pattern u_pattern (
        .word        (word),
        .row         (row_cur),
        .plane       (plane_cur),
        .line_level  (level),
        .line_enable (enable)
    );

    always_comb
    begin
        item_new.line_level    = level;
        item_new.line_enable   = enable;
        item_new.row_index     = row_cur;
        item_new.plane_index   = plane_cur;
        item_new.frame_swapped = wr.swap;
    end

    // Advance the scan: next row, and at the end of a scan repeat or step the plane.
    always_comb
    begin
        scan_row_next   = scan_row_reg;
        scan_plane_next = scan_plane_reg;
        repeat_next     = repeat_reg;
        plane_adv       = (plane_cur == PLANE_W'(PLANE_COUNT - 1)) ?
                          '0 : plane_cur + PLANE_W'(1);
        if (tick_take)
        begin
            if (row_cur == ROW_W'(ROW_COUNT))
            begin
                scan_row_next = '0;
                if (repeat_reg > REPEAT_W'(1))
                begin
                    scan_plane_next = plane_cur;
                    repeat_next     = repeat_reg - REPEAT_W'(1);
                end
                else
                begin
                    scan_plane_next = plane_adv;
                    repeat_next     = REPEAT_W'(1) << plane_adv;
                end
            end
            else
            begin
                scan_row_next   = row_cur + ROW_W'(1);
                scan_plane_next = plane_cur;
            end
        end
    end

    // Output queue: refill the result register from the skid slot first, park
    // a new item in the skid slot while the result is held.
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (result_take || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (tick_take)
            begin
                out_next       = item_new;
                out_valid_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (tick_take)
        begin
            skid_next       = item_new;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_row_reg   <= '0;
            scan_plane_reg <= '0;
            repeat_reg     <= REPEAT_W'(1);
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
            for (int n = 0; n < STORE_DEPTH; n++)
            begin
                store_reg[n] <= ENTRY_RESET;
            end
        end
        else
        begin
            scan_row_reg   <= scan_row_next;
            scan_plane_reg <= scan_plane_next;
            repeat_reg     <= repeat_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            if (tick_take && wr.wr_en)
            begin
                store_reg[wr.wr_addr] <= wr.wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    // A held skid item always sits behind a valid result.
    `CGS_ASSERT_IMPLIES(a_skid_behind_result, skid_valid_reg, out_valid_reg, "skid item without result")
    // A completed frame flips the displayed buffer on the next cycle.
    `CGS_ASSERT_NEXT(a_swap_flips_front, tick_take && wr.swap, wr.front != $past(wr.front), "swap did not flip buffers")
    // Only enabled lines are ever driven high.
    `CGS_ASSERT_IMPLIES(a_level_in_enable, result_valid, (result.line_level & ~result.line_enable) == '0, "level outside enable")
    // Results only name real scan lines and planes.
    `CGS_ASSERT_IMPLIES(a_result_range, result_valid, result.row_index <= ROW_W'(ROW_COUNT) && result.plane_index != 2'd3, "scan index out of range")

endmodule

### sv/cgs_pattern.sv
// ----------------------------------------------------------------------------
// cgs_pattern
// Builds the port levels and enables for one scan line and one bit plane.
// ----------------------------------------------------------------------------
module cgs_pattern (
    input  logic [cgs_pkg::ENTRY_W-1:0] word,
    input  logic [cgs_pkg::ROW_W-1:0]   row,
    input  logic [cgs_pkg::PLANE_W-1:0] plane,
    output logic [cgs_pkg::PORT_W-1:0]  line_level,
    output logic [cgs_pkg::PORT_W-1:0]  line_enable
);
    import cgs_pkg::*;

    localparam int COL_W  = 9;
    localparam int WIDE_W = 10;
    localparam int PIN_W  = $clog2(PORT_W);

    localparam logic [PIN_W-1:0] LINE_PIN [LINE_COUNT] = '{
        4'd0, 4'd1, 4'd2, 4'd6, 4'd7, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15
    };

    function automatic logic [PORT_W-1:0] map_lines(input logic [LINE_COUNT-1:0] logical);
        logic [PORT_W-1:0] phys;
        phys = '0;
        for (int b = 0; b < LINE_COUNT; b++)
        begin
            phys[LINE_PIN[b]] = logical[b];
        end
        return phys;
    endfunction

    logic                  is_last;
    logic [COL_W-1:0]      col_bits;
    logic [WIDE_W-1:0]     wide_bits;
    logic [LINE_COUNT-1:0] plane_bits;
    logic [LINE_COUNT-1:0] low_mask;
    logic [LINE_COUNT-1:0] spread;
    logic [LINE_COUNT-1:0] row_line;
    logic [PORT_W-1:0]     row_pin;

    always_comb
    begin
        is_last = (row == ROW_W'(ROW_COUNT));
        case (plane)
            2'd0:
            begin
                col_bits  = word[COL_W-1:0];
                wide_bits = word[WIDE_W-1:0];
            end
            2'd1:
            begin
                col_bits  = word[2*COL_W-1:COL_W];
                wide_bits = word[2*WIDE_W-1:WIDE_W];
            end
            2'd2:
            begin
                col_bits  = word[3*COL_W-1:2*COL_W];
                wide_bits = word[3*WIDE_W-1:2*WIDE_W];
            end
            default:
            begin
                col_bits  = '0;
                wide_bits = '0;
            end
        endcase

        plane_bits = is_last ? LINE_COUNT'(wide_bits) : LINE_COUNT'(col_bits);

        // Open a zero gap at the row's own line.
        low_mask = (LINE_COUNT'(1) << row) - LINE_COUNT'(1);
        spread   = (plane_bits & low_mask) | ((plane_bits & ~low_mask) << 1);
        row_line = LINE_COUNT'(1) << row;

        line_enable = map_lines(spread | row_line);
        row_pin     = map_lines(row_line);
        line_level  = (is_last ? row_pin : ~row_pin) & line_enable;
    end

endmodule

### sv/cgs_receiver.sv
// ----------------------------------------------------------------------------
// cgs_receiver
// Assembles 4-byte words from serial bytes and directs them to the back buffer.
// ----------------------------------------------------------------------------
module cgs_receiver (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       byte_take,
    input  logic [cgs_pkg::BYTE_W-1:0] rx_byte,
    output cgs_pkg::store_wr_t         wr
);
    import cgs_pkg::*;

    localparam logic [1:0] LAST_BYTE = 2'd3;
    localparam int         START_BIT = BYTE_W - 1;

    logic [WORD_W-1:0] shift_reg, shift_next;
    logic [1:0]        count_reg, count_next;
    logic              active_reg, active_next;
    logic [ROW_W-1:0]  write_row_reg, write_row_next;
    logic              front_reg, front_next;

    logic [ROW_W-1:0]  wr_row;
    logic [WORD_W-1:0] shifted;

    always_comb
    begin
        shift_next     = shift_reg;
        count_next     = count_reg;
        active_next    = active_reg;
        write_row_next = write_row_reg;
        front_next     = front_reg;

        wr_row  = (write_row_reg <= ROW_W'(ROW_COUNT)) ? write_row_reg : '0;
        shifted = {shift_reg[WORD_W-PAYLOAD_W-1:0], rx_byte[PAYLOAD_W-1:0]};

        wr.wr_en   = 1'b0;
        wr.swap    = 1'b0;
        wr.front   = front_reg;
        wr.wr_data = ENTRY_W'(shifted);
        // Back half sits at the opposite side of the front selection.
        wr.wr_addr = front_reg ? ADDR_W'(wr_row) : ADDR_W'(LINE_COUNT) + ADDR_W'(wr_row);

        if (byte_take)
        begin
            if (rx_byte[START_BIT])
            begin
                // Start byte: drop any partial word and restart.
                active_next = 1'b1;
                count_next  = 2'd1;
                shift_next  = WORD_W'(rx_byte[PAYLOAD_W-1:0]);
            end
            else if (active_reg)
            begin
                shift_next = shifted;
                if (count_reg == LAST_BYTE)
                begin
                    wr.wr_en    = 1'b1;
                    active_next = 1'b0;
                    if (wr_row == ROW_W'(ROW_COUNT))
                    begin
                        write_row_next = '0;
                        front_next     = ~front_reg;
                        wr.swap        = 1'b1;
                    end
                    else
                    begin
                        write_row_next = wr_row + ROW_W'(1);
                    end
                end
                count_next = count_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg     <= '0;
            count_reg     <= '0;
            active_reg    <= 1'b0;
            write_row_reg <= '0;
            front_reg     <= 1'b0;
        end
        else
        begin
            shift_reg     <= shift_next;
            count_reg     <= count_next;
            active_reg    <= active_next;
            write_row_reg <= write_row_next;
            front_reg     <= front_next;
        end
    end

endmodule
